// ===== src/line_junction_classifier_unit_defines.svh =====
// Assertion macros used by the line junction classifier top level.
`ifndef LINE_JUNCTION_CLASSIFIER_UNIT_DEFINES_SVH
`define LINE_JUNCTION_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LJC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LJC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ljc_pkg.sv =====
// Types and constants of the line junction classifier.
`default_nettype none

package ljc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 9;
    localparam int TIME_W   = 11;
    localparam int MASK_W   = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Junction mask codes
    localparam logic [MASK_W-1:0] MASK_NONE    = 4'b0000;
    localparam logic [MASK_W-1:0] MASK_LEFT    = 4'b0001;
    localparam logic [MASK_W-1:0] MASK_RIGHT   = 4'b0010;
    localparam logic [MASK_W-1:0] MASK_FORWARD = 4'b0100;
    localparam logic [MASK_W-1:0] MASK_DEAD    = 4'b1000;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OFF_LINE_LEVEL       = 3'd0,
        CFG_JUNCTION_START_LEVEL = 3'd1,
        CFG_BOTH_BRANCHES_LEVEL  = 3'd2,
        CFG_DRIVE_LEVEL          = 3'd3,
        CFG_JUNCTION_TIME_LIMIT  = 3'd4
    } cfg_index_t;

    // Configuration reset values
    localparam logic [SUM_W-1:0]    RST_OFF_LINE_LEVEL       = 9'd125;
    localparam logic [SUM_W-1:0]    RST_JUNCTION_START_LEVEL = 9'd340;
    localparam logic [SUM_W-1:0]    RST_BOTH_BRANCHES_LEVEL  = 9'd415;
    localparam logic [SAMPLE_W-1:0] RST_DRIVE_LEVEL          = 8'd128;
    localparam logic [TIME_W-1:0]   RST_JUNCTION_TIME_LIMIT  = 11'd150;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
    } in_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_drive;
        logic [SAMPLE_W-1:0] right_drive;
        logic [MASK_W-1:0]   junction_mask;
    } out_word_t;

    typedef struct packed {
        logic [SUM_W-1:0]    off_line_level;
        logic [SUM_W-1:0]    junction_start_level;
        logic [SUM_W-1:0]    both_branches_level;
        logic [SAMPLE_W-1:0] drive_level;
        logic [TIME_W-1:0]   junction_time_limit;
    } cfg_t;

    typedef struct packed {
        logic                tracking_junction;
        logic [TIME_W-1:0]   time_in_mode;
        logic [SUM_W-1:0]    peak_sum;
        logic [SAMPLE_W-1:0] left_at_peak;
        logic [SAMPLE_W-1:0] right_at_peak;
    } track_state_t;

endpackage

`default_nettype wire

// ===== src/ljc_step.sv =====
// One-word step logic: next tracking state, junction mask and steering drives.
`default_nettype none

module ljc_step
    import ljc_pkg::*;
(
    input  wire in_word_t     word,
    input  wire cfg_t         cfg,
    input  wire track_state_t state,
    output track_state_t      state_next,
    output logic              has_result,
    output out_word_t         result
);

    logic [SUM_W-1:0]         sum;
    logic                     lost;
    logic [MASK_W-1:0]        mask;
    track_state_t             peak_upd;
    logic signed [SUM_W-1:0]  diff;
    logic signed [SUM_W-1:0]  diff_adj;
    logic signed [SUM_W-1:0]  quarter;
    logic signed [SUM_W:0]    base;
    logic signed [SUM_W:0]    left_raw;
    logic signed [SUM_W:0]    right_raw;

    assign sum  = {1'b0, word.left_sample} + {1'b0, word.right_sample};
    assign lost = (sum < cfg.off_line_level);

    // Fold the current sample into the peak record
    always_comb begin
        peak_upd = state;
        if (sum > state.peak_sum) begin
            peak_upd.peak_sum      = sum;
            peak_upd.left_at_peak  = word.left_sample;
            peak_upd.right_at_peak = word.right_sample;
        end
    end

    // Advance tracking state and classify
    always_comb begin
        state_next = state;
        mask       = MASK_NONE;
        has_result = 1'b0;
        if (word.kind) begin
            // tick: saturating millisecond count
            if (state.time_in_mode != TIME_MAX) begin
                state_next.time_in_mode = state.time_in_mode + 1'b1;
            end
        end else begin
            has_result = 1'b1;
            if (!state.tracking_junction) begin
                if (lost) begin
                    mask = MASK_DEAD;
                end
                if (sum > cfg.junction_start_level) begin
                    state_next.tracking_junction = 1'b1;
                    state_next.time_in_mode      = '0;
                    state_next.peak_sum          = '0;
                    state_next.left_at_peak      = '0;
                    state_next.right_at_peak     = '0;
                end
            end else begin
                state_next = peak_upd;
                if (lost || (state.time_in_mode > cfg.junction_time_limit)) begin
                    if (peak_upd.peak_sum > cfg.both_branches_level) begin
                        mask = MASK_LEFT | MASK_RIGHT;
                    end else if (peak_upd.left_at_peak > peak_upd.right_at_peak) begin
                        mask = MASK_LEFT;
                    end else begin
                        mask = MASK_RIGHT;
                    end
                    if (!lost) begin
                        mask = mask | MASK_FORWARD;
                    end
                    state_next.tracking_junction = 1'b0;
                    state_next.time_in_mode      = '0;
                end
            end
        end
    end

    // Steering correction: quarter of the difference, truncated toward zero
    assign diff     = $signed({1'b0, word.left_sample}) - $signed({1'b0, word.right_sample});
    assign diff_adj = diff[SUM_W-1] ? (diff + 9'sd3) : diff;
    assign quarter  = diff_adj >>> 2;
    assign base     = $signed({2'b00, cfg.drive_level});
    assign left_raw  = base - {quarter[SUM_W-1], quarter};
    assign right_raw = base + {quarter[SUM_W-1], quarter};

    // Saturate drives, zero while reporting a junction
    always_comb begin
        result.junction_mask = mask;
        if (mask != MASK_NONE) begin
            result.left_drive  = '0;
            result.right_drive = '0;
        end else begin
            if (left_raw[SUM_W]) begin
                result.left_drive = '0;
            end else if (left_raw[SUM_W-1:SAMPLE_W] != '0) begin
                result.left_drive = '1;
            end else begin
                result.left_drive = left_raw[SAMPLE_W-1:0];
            end
            if (right_raw[SUM_W]) begin
                result.right_drive = '0;
            end else if (right_raw[SUM_W-1:SAMPLE_W] != '0) begin
                result.right_drive = '1;
            end else begin
                result.right_drive = right_raw[SAMPLE_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/line_junction_classifier_unit.sv =====
// Top level of the line junction classifier: registers, handshakes and configuration.
`default_nettype none

// Line junction classifier. Each input word is either a sensor sample pair
// or a one millisecond tick. Samples and ticks are taken one per clock
// unless a sample waits on a full output register: a word is captured in an
// input register, processed by the single-pass step logic, and a sample's
// result is loaded into the output register when the word advances; ticks
// produce no result word. The output register frees as soon as m_ready takes
// its word, so back-to-back words flow at one per cycle unless the result
// side stalls. Configuration writes are always ready and take effect on the
// following clock; write them only while no word is in flight.
module line_junction_classifier_unit
    import ljc_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    // input words
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire in_word_t         s_data,
    // result words
    output logic                  m_valid,
    input  wire                   m_ready,
    output out_word_t             m_data,
    // configuration writes
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [CFG_INDEX_W-1:0] cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data
);

`include "line_junction_classifier_unit_defines.svh"

    cfg_t         cfg_reg;
    track_state_t state_reg;
    track_state_t state_next;
    in_word_t     in_word_reg;
    logic         in_valid_reg;
    out_word_t    out_word_reg;
    logic         out_valid_reg;
    logic         step_has_result;
    out_word_t    step_result;
    logic         out_free;
    logic         advance;

    ljc_step u_step (
        .word       (in_word_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .has_result (step_has_result),
        .result     (step_result)
    );

    // Handshake control
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && (in_word_reg.kind || out_free);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_word_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.off_line_level       <= RST_OFF_LINE_LEVEL;
            cfg_reg.junction_start_level <= RST_JUNCTION_START_LEVEL;
            cfg_reg.both_branches_level  <= RST_BOTH_BRANCHES_LEVEL;
            cfg_reg.drive_level          <= RST_DRIVE_LEVEL;
            cfg_reg.junction_time_limit  <= RST_JUNCTION_TIME_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OFF_LINE_LEVEL:       cfg_reg.off_line_level <= cfg_data[SUM_W-1:0];
                CFG_JUNCTION_START_LEVEL: cfg_reg.junction_start_level <= cfg_data[SUM_W-1:0];
                CFG_BOTH_BRANCHES_LEVEL:  cfg_reg.both_branches_level <= cfg_data[SUM_W-1:0];
                CFG_DRIVE_LEVEL:          cfg_reg.drive_level <= cfg_data[SAMPLE_W-1:0];
                CFG_JUNCTION_TIME_LIMIT:  cfg_reg.junction_time_limit <= cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: capture a word whenever the stage is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // Tracking state: update once per processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Output register: load sample results, drop on acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && step_has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_has_result) begin
            out_word_reg <= step_result;
        end
    end

    `LJC_ASSERT_NOW(a_report_zero_drive, aclk, aresetn,
        m_valid && (m_data.junction_mask != MASK_NONE),
        (m_data.left_drive == '0) && (m_data.right_drive == '0),
        "junction reported with nonzero drive")
    `LJC_ASSERT_NOW(a_forward_with_branch, aclk, aresetn,
        m_valid && ((m_data.junction_mask & MASK_FORWARD) != MASK_NONE),
        (m_data.junction_mask & (MASK_LEFT | MASK_RIGHT)) != MASK_NONE,
        "forward reported without a side branch")
    `LJC_ASSERT_NOW(a_dead_end_alone, aclk, aresetn,
        m_valid && ((m_data.junction_mask & MASK_DEAD) != MASK_NONE),
        m_data.junction_mask == MASK_DEAD,
        "dead end reported together with junction bits")
    `LJC_ASSERT_NEXT(a_exit_clears_time, aclk, aresetn,
        advance && state_reg.tracking_junction && !state_next.tracking_junction,
        state_reg.time_in_mode == '0,
        "leaving junction mode did not clear the time count")

endmodule

`default_nettype wire
